// ===== rtl/lemd_pkg.sv =====
// Shared types and constants for the light edge marker detector.
package lemd_pkg;

  localparam int WINDOW      = 10;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int SAMPLE_W    = 10;
  localparam int STATUS_W    = 2;
  localparam int DIFF_W      = SAMPLE_W + 2;
  localparam int S_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((STATUS_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(5);

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_RISE = 2'd1,
    EDGE_FALL = 2'd3
  } edge_e;

  typedef enum logic [STATUS_W-1:0] {
    MARK_NONE    = 2'd0,
    MARK_FOUND   = 2'd1,
    MARK_PARTIAL = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] rd_idx;
  } ring_ctrl_t;

endpackage

// ===== rtl/light_edge_marker_detector.sv =====
// Top level of the light edge marker detector.
// Usage:
//   Slave stream: one light sample per transfer in s_axis_tdata[9:0].
//   Master stream: one marker status per sample in m_axis_tdata[1:0]
//   (0 none, 1 marker found, 2 one edge pair only).
//   cfg_we_i/cfg_wdata_i write the edge threshold; write it
//   only while no sample is in flight.
// Timing:
//   A sample is taken in SEQ_IDLE, then the ring is scanned one entry per
//   cycle, up to 10 entries (fewer when a marker ends the scan early), then
//   SEQ_DONE hands the status to the output register once it is free. The
//   single scan sequencer takes no new sample until then, and
//   s_axis_tready is low while it runs.
// Reset: threshold returns to 5, previous sample and write slot to zero,
//   all history entries to no edge, no result pending.
// Stall: the output register holds a result while m_axis_tready is low;
//   the next sample is still taken and scanned, and its result waits in the
//   sequencer until the output register frees.
module light_edge_marker_detector
  import lemd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SAMPLE_W-1:0]  cfg_wdata_i,    // edge_threshold
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [9:0] light_sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [1:0] marker_status
);

  logic [SAMPLE_W-1:0] thresh_q;
  logic                out_valid_q;
  mark_e               out_stat_q;
  logic                out_free;
  logic                res_valid;
  mark_e               res_status;
  edge_e               rd_code;
  logic [SLOT_W-1:0]   slot_next;
  ring_ctrl_t          ctrl;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_stat_q <= res_status;
    end
  end

  lemd_edge_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .thresh_i    (thresh_q),
    .rd_code_o   (rd_code),
    .slot_next_o (slot_next)
  );

  lemd_scanner u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_status_o (res_status),
    .rd_code_i    (rd_code),
    .slot_next_i  (slot_next),
    .ctrl_o       (ctrl)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - STATUS_W){1'b0}}, out_stat_q};

endmodule

// ===== rtl/lemd_edge_ring.sv =====
// Edge classifier, previous sample and ring of edge codes with its write slot.
module lemd_edge_ring
  import lemd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ring_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] thresh_i,
  output edge_e               rd_code_o,
  output logic [SLOT_W-1:0]   slot_next_o
);

  edge_e               ring_q [WINDOW];
  logic [SAMPLE_W-1:0] prev_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic signed [DIFF_W-1:0] diff, th;
  edge_e               code;

  always_comb begin
    diff = signed'({2'b00, sample_i}) - signed'({2'b00, prev_q});
    th   = signed'({2'b00, thresh_i});
    if (diff >= th) begin
      code = EDGE_RISE;
    end else if (diff <= -th) begin
      code = EDGE_FALL;
    end else begin
      code = EDGE_NONE;
    end
    slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      slot_q <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= EDGE_NONE;
      end
    end else if (ctrl_i.wr) begin
      prev_q         <= sample_i;
      slot_q         <= slot_d;
      ring_q[slot_q] <= code;
    end
  end

  assign rd_code_o   = ring_q[ctrl_i.rd_idx];
  assign slot_next_o = slot_d;

endmodule

// ===== rtl/lemd_scanner.sv =====
// Sequencer that walks the ring oldest to newest and tracks edge pairs.
module lemd_scanner
  import lemd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output mark_e             res_status_o,
  input  edge_e             rd_code_i,
  input  logic [SLOT_W-1:0] slot_next_i,
  output ring_ctrl_t        ctrl_o
);

  seq_e              state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              lrise_q, lrise_d, lfall_q, lfall_d;
  logic              rpair_q, rpair_d, fpair_q, fpair_d;
  mark_e             stat_q, stat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    lrise_q <= lrise_d;
    lfall_q <= lfall_d;
    rpair_q <= rpair_d;
    fpair_q <= fpair_d;
    stat_q  <= stat_d;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    lrise_d     = lrise_q;
    lfall_d     = lfall_q;
    rpair_d     = rpair_q;
    fpair_d     = fpair_q;
    stat_d      = stat_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ctrl_o.wr     = 1'b0;
    ctrl_o.rd_idx = idx_q;
    case (state_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.wr = 1'b1;
          idx_d     = slot_next_i;
          cnt_d     = '0;
          lrise_d   = 1'b0;
          lfall_d   = 1'b0;
          rpair_d   = 1'b0;
          fpair_d   = 1'b0;
          stat_d    = MARK_NONE;
          state_d   = SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        case (rd_code_i)
          EDGE_RISE: begin
            if (lrise_q && fpair_q) begin
              stat_d = MARK_FOUND;
            end else if (lrise_q) begin
              stat_d  = MARK_PARTIAL;
              rpair_d = 1'b1;
            end
            lrise_d = 1'b1;
            lfall_d = 1'b0;
          end
          EDGE_FALL: begin
            if (lfall_q && rpair_q) begin
              stat_d = MARK_FOUND;
            end else if (lfall_q) begin
              stat_d  = MARK_PARTIAL;
              fpair_d = 1'b1;
            end
            lrise_d = 1'b0;
            lfall_d = 1'b1;
          end
          default: begin
            lrise_d = 1'b0;
            lfall_d = 1'b0;
          end
        endcase
        idx_d = (idx_q == SLOT_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (stat_d == MARK_FOUND || cnt_q == SLOT_W'(WINDOW - 1)) begin
          state_d = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  assign res_status_o = stat_q;

endmodule
